// File: rtl/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

    // Stack geometry.
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int DEPTH_W  = 7;
    localparam int STATUS_W = 2;

    // Operation codes.
    localparam logic [FUNC_W-1:0] F_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] F_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] F_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] F_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] F_DIV  = 3'd4;
    localparam logic [FUNC_W-1:0] F_MOD  = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Request from the stack controller to the arithmetic unit.
    typedef struct packed {
        logic              start;
        logic [FUNC_W-1:0] func;
    } t_alu_req;

    // Completion report from the arithmetic unit.
    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

`default_nettype wire

// File: rtl/rpn_stack_calculator.sv
// Reverse-Polish integer calculator on a stack of 64 signed 32-bit entries.
// An item is taken when start is high and busy is low; each item yields one
// result, shown for a single cycle with o_strobe high, and the receiver cannot
// hold it off. A push, an underflow, a full stack or an unused code reports in
// the cycle after the item is taken, and busy stays low. With two or more entries,
// add, subtract, multiply, divide and modulo pass through the registered stack
// memory read of the second operand and the registered response of the
// arithmetic unit; multiply and divide or modulo also run 32 steps plus a final
// sign step through the one shared adder, which a division by zero skips. busy
// is high after such an item is taken until the strobe cycle.
`default_nettype none

module rpn_stack_calculator
    import rsc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [FUNC_W-1:0]   i_func,
    input  wire logic [DATA_W-1:0]   i_value,
    output logic                     o_strobe,
    output logic [DATA_W-1:0]        o_top_value,
    output logic [DEPTH_W-1:0]       o_depth,
    output logic [STATUS_W-1:0]      o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_top, n_top;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic                r_strobe, n_strobe;
    logic [DATA_W-1:0]   r_out_top, n_out_top;
    logic [CNT_W-1:0]    r_out_cnt, n_out_cnt;
    logic [STATUS_W-1:0] r_out_st, n_out_st;

    // Entries below the top; the top itself lives in r_top.
    logic [DATA_W-1:0]   mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    cnt_m1, cnt_m2;

    logic                accept;
    t_alu_req            alu_req;
    t_alu_rsp            alu_rsp;
    logic [DATA_W-1:0]   alu_res;

    assign accept  = start && !busy;
    assign cnt_m1  = r_count - CNT_W'(1);
    assign cnt_m2  = r_count - CNT_W'(2);
    assign rd_addr = cnt_m2[ADDR_W-1:0];
    assign wr_addr = cnt_m1[ADDR_W-1:0];

    // Controller.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_top     = r_top;
        n_func    = r_func;
        n_strobe  = 1'b0;
        n_out_top = r_out_top;
        n_out_cnt = r_out_cnt;
        n_out_st  = r_out_st;
        wr_en     = 1'b0;
        alu_req.start = 1'b0;
        alu_req.func  = r_func;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func = i_func;
                    case (i_func) inside
                        F_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count >= FULL_CNT) begin
                                n_out_top = r_top;
                                n_out_cnt = r_count;
                                n_out_st  = ST_FULL;
                            end else begin
                                // Old top drops into the memory.
                                wr_en     = (r_count != '0);
                                n_top     = i_value;
                                n_count   = r_count + CNT_W'(1);
                                n_out_top = i_value;
                                n_out_cnt = r_count + CNT_W'(1);
                                n_out_st  = ST_OK;
                            end
                        end
                        F_ADD, F_SUB, F_MUL, F_DIV, F_MOD: begin
                            if (r_count < CNT_W'(2)) begin
                                n_strobe  = 1'b1;
                                n_out_top = (r_count != '0) ? r_top : '0;
                                n_out_cnt = r_count;
                                n_out_st  = ST_UNDERFLOW;
                            end else begin
                                n_state = S_LOAD;
                            end
                        end
                        default: begin
                            n_strobe  = 1'b1;
                            n_out_top = (r_count != '0) ? r_top : '0;
                            n_out_cnt = r_count;
                            n_out_st  = ST_OK;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // Second entry is now in r_rd.
                alu_req.start = 1'b1;
                n_state       = S_CALC;
            end
            S_CALC: begin
                if (alu_rsp.done) begin
                    n_top     = alu_res;
                    n_count   = cnt_m1;
                    n_strobe  = 1'b1;
                    n_out_top = alu_res;
                    n_out_cnt = cnt_m1;
                    n_out_st  = alu_rsp.div_zero ? ST_DIVZERO : ST_OK;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Stack memory with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_top;
        end
        r_rd <= mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_func    <= n_func;
        r_out_top <= n_out_top;
        r_out_cnt <= n_out_cnt;
        r_out_st  <= n_out_st;
    end

    rsc_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (r_rd),
        .i_rhs    (r_top),
        .o_rsp    (alu_rsp),
        .o_result (alu_res)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_top_value = r_out_top;
    assign o_depth     = DEPTH_W'(r_out_cnt);
    assign o_status    = r_out_st;

endmodule

`default_nettype wire

// File: rtl/rsc_alu.sv
`default_nettype none

// Iterative arithmetic unit built around one shared 33-bit adder. Add and
// subtract finish in one step, multiply is shift-and-add over 32 steps and
// divide/modulo is restoring division over 32 steps plus a sign fix-up step.
module rsc_alu
    import rsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [DATA_W-1:0] i_lhs,
    input  wire logic [DATA_W-1:0] i_rhs,
    output t_alu_rsp               o_rsp,
    output logic      [DATA_W-1:0] o_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;
    logic              r_dz, n_dz;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_opa, n_opa;
    logic [DATA_W-1:0] r_opb, n_opb;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_neg, n_neg;
    logic              r_isdiv, n_isdiv;
    logic              r_ismul, n_ismul;

    logic [DATA_W:0]   add_a, add_b;
    logic              add_cin;
    logic [DATA_W+1:0] add_sum;
    logic [DATA_W-1:0] fin_val;

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
        magnitude = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
    endfunction

    // Value that the final step passes through, negated when required.
    assign fin_val = r_ismul ? r_acc : (r_isdiv ? r_opa : r_acc);

    // Operand selection for the shared adder.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                add_a   = {1'b0, i_lhs};
                add_b   = (i_req.func == F_SUB) ? {1'b0, ~i_rhs} : {1'b0, i_rhs};
                add_cin = (i_req.func == F_SUB);
            end
            S_MUL: begin
                add_a = {1'b0, r_acc};
                add_b = r_opb[0] ? {1'b0, r_opa} : '0;
            end
            S_DIV: begin
                add_a   = {r_acc, r_opa[DATA_W-1]};
                add_b   = ~{1'b0, r_opb};
                add_cin = 1'b1;
            end
            S_FIN: begin
                add_a   = r_neg ? '0 : {1'b0, fin_val};
                add_b   = r_neg ? {1'b0, ~fin_val} : '0;
                add_cin = r_neg;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(DATA_W+1){1'b0}}, add_cin};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_dz    = r_dz;
        n_acc   = r_acc;
        n_opa   = r_opa;
        n_opb   = r_opb;
        n_res   = r_res;
        n_neg   = r_neg;
        n_isdiv = r_isdiv;
        n_ismul = r_ismul;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_dz    = 1'b0;
                    n_cnt   = '0;
                    n_acc   = '0;
                    n_isdiv = (i_req.func == F_DIV);
                    n_ismul = (i_req.func == F_MUL);
                    case (i_req.func) inside
                        F_MUL: begin
                            n_opa   = i_lhs;
                            n_opb   = i_rhs;
                            n_neg   = 1'b0;
                            n_state = S_MUL;
                        end
                        F_DIV, F_MOD: begin
                            if (i_rhs == '0) begin
                                n_res  = '0;
                                n_dz   = 1'b1;
                                n_done = 1'b1;
                            end else begin
                                n_opa   = magnitude(i_lhs);
                                n_opb   = magnitude(i_rhs);
                                n_neg   = (i_req.func == F_DIV)
                                          ? (i_lhs[DATA_W-1] ^ i_rhs[DATA_W-1])
                                          : i_lhs[DATA_W-1];
                                n_state = S_DIV;
                            end
                        end
                        default: begin
                            n_res  = add_sum[DATA_W-1:0];
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL: begin
                n_acc = add_sum[DATA_W-1:0];
                n_opa = {r_opa[DATA_W-2:0], 1'b0};
                n_opb = {1'b0, r_opb[DATA_W-1:1]};
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                // A carry out means the trial subtraction did not go negative.
                n_acc = add_sum[DATA_W+1] ? add_sum[DATA_W-1:0]
                                          : {r_acc[DATA_W-2:0], r_opa[DATA_W-1]};
                n_opa = {r_opa[DATA_W-2:0], add_sum[DATA_W+1]};
                n_cnt = r_cnt + STEP_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res   = add_sum[DATA_W-1:0];
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_dz    <= n_dz;
        r_acc   <= n_acc;
        r_opa   <= n_opa;
        r_opb   <= n_opb;
        r_res   <= n_res;
        r_neg   <= n_neg;
        r_isdiv <= n_isdiv;
        r_ismul <= n_ismul;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.div_zero = r_dz;
    assign o_result       = r_res;

endmodule

`default_nettype wire
